[design/sorted_address_range_table_unit_macros.svh]
// Assertion helpers for the RTL files; srat_seq includes them.
`ifndef SORTED_ADDRESS_RANGE_TABLE_UNIT_MACROS_SVH
`define SORTED_ADDRESS_RANGE_TABLE_UNIT_MACROS_SVH

// Property must hold at every edge outside reset.
`define SRAT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define SRAT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

[design/srat_pkg.sv]
// ----------------------------------------------------------------------------
// srat_pkg
// Types, codes and defaults of the sorted address range table.
// ----------------------------------------------------------------------------
`default_nettype none

package srat_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_TAG_BITS    = 8;

	localparam logic [1:0] KIND_LOOKUP = 2'd0;
	localparam logic [1:0] KIND_INSERT = 2'd1;
	localparam logic [1:0] KIND_CLOSE  = 2'd2;
	localparam logic [1:0] KIND_CLEAR  = 2'd3;

	localparam logic [1:0] STATUS_DONE = 2'd0;
	localparam logic [1:0] STATUS_MISS = 2'd1;
	localparam logic [1:0] STATUS_FULL = 2'd2;

	localparam logic REG_MAIN_START = 1'b0;
	localparam logic REG_MAIN_END   = 1'b1;

	typedef struct packed {
		logic [1:0]  kind;
		logic [63:0] address;
		logic [63:0] range_end;
		logic [7:0]  tag_in;
	} req_t;

	typedef struct packed {
		logic        hit;
		logic        in_main;
		logic [7:0]  tag_out;
		logic [63:0] found_start;
		logic [63:0] found_end;
		logic [1:0]  status;
	} rsp_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_FLAG,
		CELL_PASS,
		CELL_CLOSE,
		CELL_SWAP,
		CELL_INSERT
	} cell_op_t;

	typedef struct packed {
		cell_op_t    op;
		logic        phase;
		logic [63:0] address;
		logic [63:0] range_end;
		logic [7:0]  tag;
	} cell_ctrl_t;

	// lt/eq are registered search flags, gt/hole are live
	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
		logic hole;
	} cell_flags_t;

	// search result travelling down the row
	typedef struct packed {
		logic        hit;
		logic [7:0]  tag;
		logic [63:0] start;
		logic [63:0] stop;
	} carry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FLAG,
		ST_PASS,
		ST_FINISH,
		ST_SWAP,
		ST_INSERT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

[design/srat_cell.sv]
// ----------------------------------------------------------------------------
// srat_cell
// One table entry with its local search, compaction and insert logic.
// ----------------------------------------------------------------------------
`default_nettype none

module srat_cell #(
	parameter int TABLE_DEPTH = 64,
	parameter int TAG_BITS    = 8,
	parameter int INDEX       = 0
) (
	input  wire                                      clk,
	input  srat_pkg::cell_ctrl_t                     ctrl,
	input  wire [$clog2(TABLE_DEPTH+1)-1:0]          count,
	input  srat_pkg::cell_flags_t                    prev_flags,
	input  srat_pkg::cell_flags_t                    next_flags,
	input  wire [63:0]                               prev_start,
	input  wire [63:0]                               prev_end,
	input  wire [TAG_BITS-1:0]                       prev_tag,
	input  wire                                      prev_open,
	input  wire [63:0]                               next_start,
	input  wire [63:0]                               next_end,
	input  wire [TAG_BITS-1:0]                       next_tag,
	input  wire                                      next_open,
	input  srat_pkg::carry_t                         prev_carry,
	output srat_pkg::cell_flags_t                    flags,
	output logic [63:0]                              start,
	output logic [63:0]                              stop,
	output logic [TAG_BITS-1:0]                      tag,
	output logic                                     open,
	output srat_pkg::carry_t                         carry
);
	import srat_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int TN = (TAG_BITS < 8) ? TAG_BITS : 8;
	localparam logic [CW-1:0] IDX = CW'(INDEX);
	localparam bit FIRST = (INDEX == 0);
	localparam bit LAST  = (INDEX == TABLE_DEPTH - 1);
	localparam bit ODD   = (INDEX % 2) == 1;

	logic [63:0]         start_q, end_q;
	logic [TAG_BITS-1:0] tag_q;
	logic                open_q;
	logic                lt_q, eq_q, contains_q;
	carry_t              carry_q;

	logic                valid, hole, gt, sel, is_left, take, new_here;
	logic [63:0]         start_d, end_d;
	logic [TAG_BITS-1:0] tag_d, tag_new;
	logic                open_d;
	logic [7:0]          tag8;

	assign valid = IDX < count;
	assign hole  = !valid || !open_q;
	assign gt    = valid && (start_q > ctrl.address);

	// first entry at or above the address if it starts there, else the one before
	assign sel = contains_q && ((eq_q && (FIRST || prev_flags.lt))
		|| (lt_q && !next_flags.lt && !next_flags.eq));

	assign is_left  = (ODD == ctrl.phase);
	assign new_here = !prev_flags.gt && (gt || (IDX == count));

	always_comb begin
		if (is_left) begin
			take = !LAST && hole && !next_flags.hole;
		end else begin
			take = !FIRST && prev_flags.hole && !hole;
		end
	end

	always_comb begin
		tag_new = '0;
		tag8    = '0;
		for (int b = 0; b < TN; b++) begin
			tag_new[b] = ctrl.tag[b];
			tag8[b]    = tag_q[b];
		end
	end

	always_comb begin
		start_d = start_q;
		end_d   = end_q;
		tag_d   = tag_q;
		open_d  = open_q;
		unique case (ctrl.op)
			CELL_SWAP: begin
				if (take && is_left) begin
					start_d = next_start;
					end_d   = next_end;
					tag_d   = next_tag;
					open_d  = next_open;
				end else if (take) begin
					start_d = prev_start;
					end_d   = prev_end;
					tag_d   = prev_tag;
					open_d  = prev_open;
				end
			end
			CELL_INSERT: begin
				if (!FIRST && prev_flags.gt) begin
					start_d = prev_start;
					end_d   = prev_end;
					tag_d   = prev_tag;
					open_d  = prev_open;
				end else if (new_here) begin
					start_d = ctrl.address;
					end_d   = ctrl.range_end;
					tag_d   = tag_new;
					open_d  = 1'b1;
				end
			end
			CELL_CLOSE: begin
				if (sel) begin
					end_d  = start_q;
					open_d = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		start_q <= start_d;
		end_q   <= end_d;
		tag_q   <= tag_d;
		open_q  <= open_d;
		if (ctrl.op == CELL_FLAG) begin
			lt_q       <= valid && (start_q < ctrl.address);
			eq_q       <= valid && (start_q == ctrl.address);
			contains_q <= valid && (start_q <= ctrl.address) && (ctrl.address < end_q);
		end
		if (ctrl.op == CELL_PASS) begin
			carry_q <= sel ? carry_t'{1'b1, tag8, start_q, end_q} : prev_carry;
		end
	end

	assign flags = cell_flags_t'{lt_q, eq_q, gt, hole};
	assign start = start_q;
	assign stop  = end_q;
	assign tag   = tag_q;
	assign open  = open_q;
	assign carry = carry_q;

endmodule

`default_nettype wire

[design/srat_seq.sv]
// ----------------------------------------------------------------------------
// srat_seq
// Command sequencer: handshakes, main range, entry counts, result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_address_range_table_unit_macros.svh"

module srat_seq #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              req_valid,
	output logic                             req_ready,
	input  srat_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  wire                              rsp_ready,
	output srat_pkg::rsp_t                   rsp,
	input  wire                              wr_en,
	input  wire                              wr_index,
	input  wire [63:0]                       wr_data,
	output srat_pkg::cell_ctrl_t             ctrl,
	output logic [$clog2(TABLE_DEPTH+1)-1:0] count,
	input  srat_pkg::carry_t                 last_carry
);
	import srat_pkg::*;

	localparam int CW   = $clog2(TABLE_DEPTH + 1);
	localparam int CNTW = $clog2(TABLE_DEPTH);
	localparam logic [CW-1:0]   FULL_COUNT = CW'(TABLE_DEPTH);
	localparam logic [CNTW-1:0] LAST_STEP  = CNTW'(TABLE_DEPTH - 1);

	state_t          state_q, state_d;
	logic [CNTW-1:0] step_q;
	logic [CW-1:0]   count_q, open_count_q;
	logic [63:0]     main_start_q, main_end_q;
	logic            rsp_valid_q;
	req_t            req_q;
	rsp_t            res_q, rsp_q, accept_res;
	logic            accept, main_hit, full, last_step, load_rsp;

	assign accept    = req_valid && req_ready;
	assign main_hit  = (req.kind == KIND_LOOKUP) && (req.address >= main_start_q)
		&& (req.address < main_end_q);
	assign full      = open_count_q == FULL_COUNT;
	assign last_step = step_q == LAST_STEP;
	assign load_rsp  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		accept_res        = '0;
		accept_res.status = STATUS_DONE;
		if (main_hit) begin
			accept_res.hit         = 1'b1;
			accept_res.in_main     = 1'b1;
			accept_res.found_start = main_start_q;
			accept_res.found_end   = main_end_q;
		end else if ((req.kind == KIND_INSERT) && full) begin
			accept_res.status = STATUS_FULL;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					priority if (main_hit) begin
						state_d = ST_DONE;
					end else if ((req.kind == KIND_LOOKUP) || (req.kind == KIND_CLOSE)) begin
						state_d = ST_FLAG;
					end else if ((req.kind == KIND_INSERT) && !full) begin
						state_d = ST_SWAP;
					end else begin
						state_d = ST_DONE;
					end
				end
			end
			ST_FLAG:   state_d = ST_PASS;
			ST_PASS:   state_d = last_step ? ST_FINISH : ST_PASS;
			ST_FINISH: state_d = ST_DONE;
			ST_SWAP:   state_d = last_step ? ST_INSERT : ST_SWAP;
			ST_INSERT: state_d = ST_DONE;
			ST_DONE:   state_d = load_rsp ? ST_IDLE : ST_DONE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		req_ready       = state_q == ST_IDLE;
		ctrl.phase      = step_q[0];
		ctrl.address    = req_q.address;
		ctrl.range_end  = req_q.range_end;
		ctrl.tag        = req_q.tag_in;
		unique case (state_q)
			ST_FLAG:   ctrl.op = CELL_FLAG;
			ST_PASS:   ctrl.op = CELL_PASS;
			ST_FINISH: ctrl.op = (req_q.kind == KIND_CLOSE) ? CELL_CLOSE : CELL_HOLD;
			ST_SWAP:   ctrl.op = CELL_SWAP;
			ST_INSERT: ctrl.op = CELL_INSERT;
			default:   ctrl.op = CELL_HOLD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			step_q       <= '0;
			count_q      <= '0;
			open_count_q <= '0;
			main_start_q <= '0;
			main_end_q   <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= ((state_q == ST_PASS) || (state_q == ST_SWAP)) && !last_step
				? step_q + 1'b1 : '0;
			if (wr_en && (wr_index == REG_MAIN_START)) begin
				main_start_q <= wr_data;
			end
			if (wr_en && (wr_index == REG_MAIN_END)) begin
				main_end_q <= wr_data;
			end
			if (accept && (req.kind == KIND_CLEAR)) begin
				count_q      <= '0;
				open_count_q <= '0;
			end
			if ((state_q == ST_SWAP) && last_step) begin
				count_q <= open_count_q;
			end
			if (state_q == ST_INSERT) begin
				count_q      <= count_q + 1'b1;
				open_count_q <= open_count_q + 1'b1;
			end
			if ((state_q == ST_FINISH) && (req_q.kind == KIND_CLOSE) && last_carry.hit) begin
				open_count_q <= open_count_q - 1'b1;
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
			res_q <= accept_res;
		end
		if (state_q == ST_FINISH) begin
			res_q.hit         <= last_carry.hit;
			res_q.in_main     <= 1'b0;
			res_q.tag_out     <= last_carry.tag;
			res_q.found_start <= last_carry.start;
			res_q.found_end   <= last_carry.stop;
			res_q.status      <= last_carry.hit ? STATUS_DONE : STATUS_MISS;
		end
		if (load_rsp) begin
			rsp_q <= res_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign count     = count_q;

	`SRAT_NEVER(a_open_le_count, open_count_q > count_q, "open entries exceed entry count")
	`SRAT_NEVER(a_count_le_depth, count_q > FULL_COUNT, "entry count above table depth")
	`SRAT_ASSERT(a_clear_empties, accept && (req.kind == KIND_CLEAR) |=> count_q == '0, "clear left entries")
	`SRAT_ASSERT(a_insert_grows, state_q == ST_INSERT |=> count_q == $past(open_count_q) + 1'b1, "insert count wrong")

endmodule

`default_nettype wire

[design/sorted_address_range_table_unit.sv]
// ----------------------------------------------------------------------------
// sorted_address_range_table_unit
// Address range table kept sorted by start, with a separate main range.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries one command: lookup, insert, close or clear.
//   rsp (valid/ready) returns exactly one result per command, in order.
//   wr_en/wr_index/wr_data set main_start (0) and main_end (1); write only
//   while no command is in flight.
// Sequence (N = TABLE_DEPTH, one command at a time, from the req transfer
// to the result entering the output register):
//   main-range hit, clear, insert on a full table: straight to the done step.
//   lookup or close in the table: flag, pass and finish steps; the pass part
//   is the result token walking the row of cells, one cell per cycle.
//   insert: N odd-even rounds squeeze closed entries out of the row, then
//   the insert step shifts the upper entries and drops the new one in.
//   req_ready rises in the same cycle that the result enters the output register.
// Reset clears the counts, main range and handshakes; entry contents are
// undefined but never read because the entry count is zero.
// A stalled rsp holds its transfer; the next command is still taken and
// its result waits in the sequencer until the output register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_address_range_table_unit #(
	parameter int TABLE_DEPTH = srat_pkg::DEF_TABLE_DEPTH,
	parameter int TAG_BITS    = srat_pkg::DEF_TAG_BITS
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              req_valid,
	output logic             req_ready,
	input  srat_pkg::req_t   req,
	output logic             rsp_valid,
	input  wire              rsp_ready,
	output srat_pkg::rsp_t   rsp,
	input  wire              wr_en,
	input  wire              wr_index,
	input  wire [63:0]       wr_data
);
	import srat_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	cell_ctrl_t          ctrl;
	logic [CW-1:0]       count;

	// per-cell outputs, wired to both neighbors; carries go to the next cell only
	cell_flags_t         flags [TABLE_DEPTH];
	logic [63:0]         starts [TABLE_DEPTH];
	logic [63:0]         stops [TABLE_DEPTH];
	logic [TAG_BITS-1:0] tags [TABLE_DEPTH];
	logic                opens [TABLE_DEPTH];
	carry_t              carries [TABLE_DEPTH];

	srat_seq #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.rsp_valid  (rsp_valid),
		.rsp_ready  (rsp_ready),
		.rsp        (rsp),
		.wr_en      (wr_en),
		.wr_index   (wr_index),
		.wr_data    (wr_data),
		.ctrl       (ctrl),
		.count      (count),
		.last_carry (carries[TABLE_DEPTH-1])
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		cell_flags_t         p_flags, n_flags;
		logic [63:0]         p_start, p_stop, n_start, n_stop;
		logic [TAG_BITS-1:0] p_tag, n_tag;
		logic                p_open, n_open;
		carry_t              p_carry;

		// row ends see empty neighbors
		if (i == 0) begin : g_head
			assign p_flags = '0;
			assign p_start = '0;
			assign p_stop  = '0;
			assign p_tag   = '0;
			assign p_open  = 1'b0;
			assign p_carry = '0;
		end else begin : g_prev
			assign p_flags = flags[i-1];
			assign p_start = starts[i-1];
			assign p_stop  = stops[i-1];
			assign p_tag   = tags[i-1];
			assign p_open  = opens[i-1];
			assign p_carry = carries[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_tail
			assign n_flags = '0;
			assign n_start = '0;
			assign n_stop  = '0;
			assign n_tag   = '0;
			assign n_open  = 1'b0;
		end else begin : g_next
			assign n_flags = flags[i+1];
			assign n_start = starts[i+1];
			assign n_stop  = stops[i+1];
			assign n_tag   = tags[i+1];
			assign n_open  = opens[i+1];
		end

		srat_cell #(
			.TABLE_DEPTH(TABLE_DEPTH),
			.TAG_BITS   (TAG_BITS),
			.INDEX      (i)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.count      (count),
			.prev_flags (p_flags),
			.next_flags (n_flags),
			.prev_start (p_start),
			.prev_end   (p_stop),
			.prev_tag   (p_tag),
			.prev_open  (p_open),
			.next_start (n_start),
			.next_end   (n_stop),
			.next_tag   (n_tag),
			.next_open  (n_open),
			.prev_carry (p_carry),
			.flags      (flags[i]),
			.start      (starts[i]),
			.stop       (stops[i]),
			.tag        (tags[i]),
			.open       (opens[i]),
			.carry      (carries[i])
		);
	end

endmodule

`default_nettype wire
